// File: sv/sem_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the RGB Sobel edge magnitude block.
// No dependencies; every other file in sv/ except sem_ram refers to it by scoped names.
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int CHAN_W    = 8;
  localparam int NUM_LANES = 3;
  localparam int PIX_W     = CHAN_W * NUM_LANES;
  localparam int WIN_N     = 9;
  localparam int DIM_W     = 11;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int POS_W     = 10;
  localparam int SUM_W     = CHAN_W + 2;
  localparam int MAG_W     = SUM_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = OUTQ_AW + 2;

  typedef logic [WIN_N-1:0][CHAN_W-1:0] lane_win_t;

  typedef struct packed {
    logic s2_emit;
    logic s3_emit;
    logic s3_last;
  } lane_ctl_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][MAG_W-1:0] mag;
    logic [NUM_LANES-1:0][MAG_W-1:0] peak;
    logic [POS_W-1:0]                row;
    logic [POS_W-1:0]                col;
    logic                            done;
  } res_t;

endpackage

// File: sv/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// Top level: RGB streaming 3x3 Sobel edge magnitude with line stores and per-frame peaks.
// Depends on sem_pkg, sem_ram, sem_lane and sem_outq.
//
//   channel | signals                                      | direction
//   cfg     | cfg_we, cfg_index, cfg_data                  | write only
//   in      | in_valid/in_ready, chan_a..chan_c            | pixel requests
//   out     | out_valid/out_ready, mag_*, out_row, out_col,| result requests
//           | peak_*, frame_done                           |
//
// One pixel per cycle while in_ready is high; a taken pixel passes the p1 register, the window shift,
// the lane register and the queue write before its result shows on out_valid.
// Reset clears counters, window, peaks and the 8-entry result queue; line stores are not cleared.
// With out_ready low the queue fills; in_ready drops once queued plus in-flight results reach 8.
module sobel_edge_magnitude_rgb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    chan_a,
  input  logic [7:0]                    chan_b,
  input  logic [7:0]                    chan_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [10:0]                   mag_a,
  output logic [10:0]                   mag_b,
  output logic [10:0]                   mag_c,
  output logic [9:0]                    out_row,
  output logic [9:0]                    out_col,
  output logic [10:0]                   peak_a,
  output logic [10:0]                   peak_b,
  output logic [10:0]                   peak_c,
  output logic                          frame_done
);

  logic [sem_pkg::DIM_W-1:0] frame_width, frame_height;
  logic [sem_pkg::DIM_W-1:0] w_use, h_use, col_ext, row_ext;
  logic [sem_pkg::COL_W-1:0] col;
  logic [sem_pkg::ROW_W-1:0] row;
  logic                      accept, emit0, last0;
  logic [sem_pkg::PIX_W-1:0] pix, up_q, mid_q;

  logic                      p1_valid, p1_emit, p1_last;
  logic [sem_pkg::COL_W-1:0] p1_addr;
  logic [sem_pkg::PIX_W-1:0] p1_pix;
  logic [sem_pkg::POS_W-1:0] p1_row, p1_col, p2_row, p2_col, p3_row, p3_col;
  logic                      p2_emit, p2_last, p3_emit, p3_last;

  logic [sem_pkg::PIX_W-1:0] win [sem_pkg::WIN_N];
  sem_pkg::lane_ctl_t        lane_ctl;
  logic [sem_pkg::NUM_LANES-1:0][sem_pkg::MAG_W-1:0] lane_mag, lane_peak;

  logic [sem_pkg::OUTQ_CW-1:0] q_count, inflight;
  sem_pkg::res_t               head;

  function automatic logic [sem_pkg::DIM_W-1:0] clamp_dim(
    input logic [sem_pkg::DIM_W-1:0] v,
    input logic [sem_pkg::DIM_W-1:0] hi
  );
    if (v < sem_pkg::DIM_W'(sem_pkg::MIN_DIM)) begin
      return sem_pkg::DIM_W'(sem_pkg::MIN_DIM);
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::WIDTH_RESET;
      frame_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept stage
  always_comb begin
    w_use   = clamp_dim(frame_width, sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH));
    h_use   = clamp_dim(frame_height, sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT));
    col_ext = sem_pkg::DIM_W'(col);
    row_ext = sem_pkg::DIM_W'(row);
    accept  = in_valid && in_ready;
    pix     = {chan_c, chan_b, chan_a};
    emit0   = (row_ext >= sem_pkg::DIM_W'(2)) && (col_ext >= sem_pkg::DIM_W'(2)) &&
              (row_ext < h_use) && (col_ext < w_use);
    last0   = (row_ext == h_use - sem_pkg::DIM_W'(1)) &&
              (col_ext == w_use - sem_pkg::DIM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_ext + sem_pkg::DIM_W'(1) >= w_use) begin
        col <= '0;
        if (row_ext + sem_pkg::DIM_W'(1) >= h_use) begin
          row <= '0;
        end else begin
          row <= row + sem_pkg::ROW_W'(1);
        end
      end else begin
        col <= col + sem_pkg::COL_W'(1);
      end
    end
  end

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pix),
    .raddr (col),
    .rdata (mid_q)
  );

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (p1_valid),
    .waddr (p1_addr),
    .wdata (mid_q),
    .raddr (col),
    .rdata (up_q)
  );

  // line-store data stage, window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p1_emit  <= 1'b0;
      p2_emit  <= 1'b0;
      p3_emit  <= 1'b0;
    end else begin
      p1_valid <= accept;
      p1_emit  <= accept && emit0;
      p2_emit  <= p1_emit;
      p3_emit  <= p2_emit;
    end
  end

  always_ff @(posedge clk) begin
    p1_last <= last0;
    p1_addr <= col;
    p1_pix  <= pix;
    p1_row  <= sem_pkg::POS_W'(row - sem_pkg::ROW_W'(1));
    p1_col  <= sem_pkg::POS_W'(col - sem_pkg::COL_W'(1));
    p2_last <= p1_last;
    p2_row  <= p1_row;
    p2_col  <= p1_col;
    p3_last <= p2_last;
    p3_row  <= p2_row;
    p3_col  <= p2_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sem_pkg::WIN_N; i++) begin
        win[i] <= '0;
      end
    end else if (p1_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= up_q;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid_q;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= p1_pix;
    end
  end

  always_comb begin
    lane_ctl.s2_emit = p2_emit;
    lane_ctl.s3_emit = p3_emit;
    lane_ctl.s3_last = p3_last;
  end

  for (genvar k = 0; k < sem_pkg::NUM_LANES; k++) begin : g_lane
    sem_pkg::lane_win_t lane_win;

    always_comb begin
      for (int i = 0; i < sem_pkg::WIN_N; i++) begin
        lane_win[i] = win[i][k*sem_pkg::CHAN_W +: sem_pkg::CHAN_W];
      end
    end

    sem_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .win      (lane_win),
      .ctl      (lane_ctl),
      .mag      (lane_mag[k]),
      .peak_out (lane_peak[k])
    );
  end

  sem_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (p3_emit),
    .lane_mag   (lane_mag),
    .lane_peak  (lane_peak),
    .row        (p3_row),
    .col        (p3_col),
    .last       (p3_last),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .count      (q_count)
  );

  // hold input once queued and in-flight results could fill the queue
  always_comb begin
    inflight = sem_pkg::OUTQ_CW'(p1_emit) + sem_pkg::OUTQ_CW'(p2_emit) +
               sem_pkg::OUTQ_CW'(p3_emit);
    in_ready = (q_count + inflight) < sem_pkg::OUTQ_CW'(sem_pkg::OUTQ_DEPTH);
  end

  assign mag_a      = head.mag[0];
  assign mag_b      = head.mag[1];
  assign mag_c      = head.mag[2];
  assign peak_a     = head.peak[0];
  assign peak_b     = head.peak[1];
  assign peak_c     = head.peak[2];
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign frame_done = head.done;

endmodule

// File: sv/sem_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read-first output.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: sv/sem_lane.sv
`timescale 1ns / 1ps
// One color channel: Sobel |Gx|+|Gy| over a 3x3 window and the running frame peak.
// Depends on sem_pkg.
module sem_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  sem_pkg::lane_win_t         win,
  input  sem_pkg::lane_ctl_t         ctl,
  output logic [sem_pkg::MAG_W-1:0]  mag,
  output logic [sem_pkg::MAG_W-1:0]  peak_out
);

  logic [sem_pkg::SUM_W-1:0] left, right, top, bot;
  logic [sem_pkg::SUM_W-1:0] abs_x, abs_y;
  logic [sem_pkg::MAG_W-1:0] peak;

  function automatic logic [sem_pkg::SUM_W-1:0] col_sum(
    input logic [sem_pkg::CHAN_W-1:0] a,
    input logic [sem_pkg::CHAN_W-1:0] b,
    input logic [sem_pkg::CHAN_W-1:0] c
  );
    return sem_pkg::SUM_W'(a) + (sem_pkg::SUM_W'(b) << 1) + sem_pkg::SUM_W'(c);
  endfunction

  always_comb begin
    left  = col_sum(win[0], win[3], win[6]);
    right = col_sum(win[2], win[5], win[8]);
    top   = col_sum(win[0], win[1], win[2]);
    bot   = col_sum(win[6], win[7], win[8]);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_emit) begin
      abs_x <= (left >= right) ? left - right : right - left;
      abs_y <= (top >= bot) ? top - bot : bot - top;
    end
  end

  always_comb begin
    mag      = sem_pkg::MAG_W'(abs_x) + sem_pkg::MAG_W'(abs_y);
    peak_out = (mag > peak) ? mag : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (ctl.s3_emit) begin
      peak <= ctl.s3_last ? '0 : peak_out;
    end
  end

endmodule

// File: sv/sem_outq.sv
`timescale 1ns / 1ps
// Merges the lane results with position and frame flag into one request and queues it.
// Depends on sem_pkg.
module sem_outq (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  input  logic [sem_pkg::NUM_LANES-1:0][sem_pkg::MAG_W-1:0] lane_mag,
  input  logic [sem_pkg::NUM_LANES-1:0][sem_pkg::MAG_W-1:0] lane_peak,
  input  logic [sem_pkg::POS_W-1:0]                     row,
  input  logic [sem_pkg::POS_W-1:0]                     col,
  input  logic                                          last,
  input  logic                                          pop_ready,
  output logic                                          head_valid,
  output sem_pkg::res_t                                 head,
  output logic [sem_pkg::OUTQ_CW-1:0]                   count
);

  sem_pkg::res_t                 q [sem_pkg::OUTQ_DEPTH];
  sem_pkg::res_t                 entry;
  logic [sem_pkg::OUTQ_AW-1:0]   wr_ptr, rd_ptr;
  logic                          pop;

  always_comb begin
    entry.mag  = lane_mag;
    entry.peak = lane_peak;
    entry.row  = row;
    entry.col  = col;
    entry.done = last;
  end

  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign pop        = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sem_pkg::OUTQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sem_pkg::OUTQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + sem_pkg::OUTQ_CW'(1);
        2'b01:   count <= count - sem_pkg::OUTQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude_rgb: pixel frames in, edge results checked.
// Depends on sem_pkg and the RTL in sv/; holds its own Sobel predictor and result scoreboard.
module testbench;

  localparam int unsigned RANDOM_PIXELS = 1300;
  localparam int unsigned CALM_TAIL     = 200;
  localparam int unsigned RESET_PIXELS  = 40;
  localparam int unsigned WIDE_PIXELS   = 60;
  localparam int unsigned TALL_ROWS     = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned GAP_MAX       = 17;
  localparam int unsigned DRAIN_LIMIT   = 100000;
  localparam logic [sem_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sem_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} texture_t;

  class edge_scoreboard;
    logic [23:0]   upper_line [sem_pkg::MAX_WIDTH];
    logic [23:0]   middle_line [sem_pkg::MAX_WIDTH];
    bit            upper_known [sem_pkg::MAX_WIDTH];
    bit            middle_known [sem_pkg::MAX_WIDTH];
    logic [23:0]   window [9];
    int unsigned   row_pos;
    int unsigned   col_pos;
    logic [10:0]   peak [3];
    logic [10:0]   width_reg;
    logic [10:0]   height_reg;
    sem_pkg::res_t pending_edges [$];
    int            failures;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
        upper_known[i] = 1'b0;
        middle_known[i] = 1'b0;
      end
      foreach (window[i]) window[i] = '0;
      foreach (peak[i]) peak[i] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = sem_pkg::WIDTH_RESET;
      height_reg = sem_pkg::HEIGHT_RESET;
      failures = 0;
    endfunction

    function int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
      if (v < sem_pkg::MIN_DIM) return sem_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_cols();
      return clamp_dim(width_reg, sem_pkg::MAX_WIDTH);
    endfunction

    function int unsigned frame_rows();
      return clamp_dim(height_reg, sem_pkg::MAX_HEIGHT);
    endfunction

    function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    // columns below this count hold written data in both line stores
    function int unsigned known_cols();
      int unsigned n;
      n = 0;
      while (n < sem_pkg::MAX_WIDTH && upper_known[n] && middle_known[n]) n++;
      return n;
    endfunction

    function void write_reg(logic [sem_pkg::CFG_IDX_W-1:0] index, logic [10:0] value);
      case (index)
        sem_pkg::REG_FRAME_WIDTH: width_reg = value;
        sem_pkg::REG_FRAME_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function logic [10:0] sobel_lane_magnitude(int lane);
      int unsigned s [9];
      int unsigned left, right, top, bottom, gx, gy;
      foreach (s[i]) s[i] = window[i][8*lane +: 8];
      left   = s[0] + 2 * s[3] + s[6];
      right  = s[2] + 2 * s[5] + s[8];
      top    = s[0] + 2 * s[1] + s[2];
      bottom = s[6] + 2 * s[7] + s[8];
      gx = (left >= right) ? left - right : right - left;
      gy = (top >= bottom) ? top - bottom : bottom - top;
      return 11'(gx + gy);
    endfunction

    function void note_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic [23:0]   pix, up, mid;
      logic [10:0]   m;
      int unsigned   w, h, r, col;
      bit            closing;
      sem_pkg::res_t res;
      pix = {c, b, a};
      w = frame_cols();
      h = frame_rows();
      r = row_pos;
      col = col_pos;
      up = '0;
      mid = '0;
      if (col < sem_pkg::MAX_WIDTH) begin
        up = upper_line[col];
        mid = middle_line[col];
        upper_line[col] = mid;
        middle_line[col] = pix;
        upper_known[col] = middle_known[col];
        middle_known[col] = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        window[i*3] = window[i*3+1];
        window[i*3+1] = window[i*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = pix;
      if (r >= 2 && col >= 2 && r < h && col < w) begin
        closing = (r == h - 1) && (col == w - 1);
        for (int lane = 0; lane < 3; lane++) begin
          m = sobel_lane_magnitude(lane);
          if (m > peak[lane]) peak[lane] = m;
          res.mag[lane] = m;
          res.peak[lane] = peak[lane];
        end
        res.row = 10'(r - 1);
        res.col = 10'(col - 1);
        res.done = closing;
        if (closing) foreach (peak[i]) peak[i] = '0;
        pending_edges.push_back(res);
      end
      if (col + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = col + 1;
      end
    endfunction

    function void compare_field(string what, logic [10:0] want, logic [10:0] have);
      if (have !== want) begin
        $display("%0t ns: %s expected %0d actual %0d", $time, what, want, have);
        failures++;
      end
    endfunction

    function void check_result(sem_pkg::res_t got);
      sem_pkg::res_t want;
      if (pending_edges.size() == 0) begin
        $display("%0t ns: result with none expected, row %0d col %0d", $time, got.row, got.col);
        failures++;
        return;
      end
      want = pending_edges.pop_front();
      for (int lane = 0; lane < 3; lane++) begin
        compare_field($sformatf("mag lane %0d", lane), want.mag[lane], got.mag[lane]);
        compare_field($sformatf("peak lane %0d", lane), want.peak[lane], got.peak[lane]);
      end
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("frame_done", want.done, got.done);
    endfunction

    function void report_leftover();
      if (pending_edges.size() != 0) begin
        $display("%0t ns: %0d expected results never arrived", $time, pending_edges.size());
        failures++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we;
  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sem_pkg::DIM_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    chan_a, chan_b, chan_c;
  logic                          out_valid;
  logic                          out_ready;
  logic [10:0]                   mag_a, mag_b, mag_c;
  logic [9:0]                    out_row, out_col;
  logic [10:0]                   peak_a, peak_b, peak_c;
  logic                          frame_done;

  edge_scoreboard board;
  bit             calm = 1'b0;

  sobel_edge_magnitude_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .chan_a     (chan_a),
    .chan_b     (chan_b),
    .chan_c     (chan_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mag_a      (mag_a),
    .mag_b      (mag_b),
    .mag_c      (mag_c),
    .out_row    (out_row),
    .out_col    (out_col),
    .peak_a     (peak_a),
    .peak_b     (peak_b),
    .peak_c     (peak_c),
    .frame_done (frame_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, GAP_MAX);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    sem_pkg::res_t got;
    if (!rst && out_valid && out_ready) begin
      got.mag[0] = mag_a;
      got.mag[1] = mag_b;
      got.mag[2] = mag_c;
      got.peak[0] = peak_a;
      got.peak[1] = peak_b;
      got.peak[2] = peak_c;
      got.row = out_row;
      got.col = out_col;
      got.done = frame_done;
      board.check_result(got);
    end
  end

  function automatic logic [7:0] texel(texture_t tex);
    case (tex)
      TEXTURE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      TEXTURE_FLAT:   return 8'($urandom_range(120, 135));
      default:        return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [10:0] pick_dim();
    if ($urandom_range(0, 15) == 0) return 11'($urandom_range(0, sem_pkg::MIN_DIM - 1));
    return 11'($urandom_range(sem_pkg::MIN_DIM, 12));
  endfunction

  task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] index, input logic [10:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(index, value);
  endtask

  task automatic push_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    in_valid <= 1'b1;
    chan_a <= a;
    chan_b <= b;
    chan_c <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(a, b, c);
  endtask

  task automatic push_random(input texture_t tex);
    push_pixel(texel(tex), texel(tex), texel(tex));
  endtask

  // drop valid, wait out every pending result and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent, n, w, h, r, c;
    logic [10:0] w_val, h_val;
    texture_t    tex;
    board = new();
    cfg_we <= 1'b0;
    cfg_index <= sem_pkg::REG_FRAME_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    chan_a <= '0;
    chan_b <= '0;
    chan_c <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: part of the first row, then shrink mid-frame
    repeat (RESET_PIXELS) push_random(TEXTURE_NOISE);
    settle();
    write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd30);
    write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'd3);
    while (!board.at_frame_start()) push_random(TEXTURE_NOISE);

    // smallest frames with vertical, horizontal and diagonal steps, then inverted
    settle();
    write_reg(sem_pkg::REG_FRAME_WIDTH, 11'(sem_pkg::MIN_DIM));
    write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'(sem_pkg::MIN_DIM));
    for (int f = 0; f < 2; f++) begin
      if (f == 1) begin
        settle();
        write_reg(REG_SPARE_A, 11'd5);
        write_reg(REG_SPARE_B, 11'h7FF);
      end
      for (int i = 0; i < 9; i++) begin
        r = i / 3;
        c = i % 3;
        push_pixel((c == 2) ? ~8'(f * 255) : 8'(f * 255),
                   (r == 2) ? ~8'(f * 255) : 8'(f * 255),
                   (r + c >= 3) ? ~8'(f * 255) : 8'(f * 255));
      end
    end

    // widest row cut short, then clamped geometry entered mid-frame
    settle();
    write_reg(sem_pkg::REG_FRAME_WIDTH, 11'(sem_pkg::MAX_WIDTH));
    write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'(sem_pkg::MIN_DIM));
    repeat (WIDE_PIXELS) push_random(TEXTURE_NOISE);
    settle();
    write_reg(sem_pkg::REG_FRAME_WIDTH, 11'd0);
    write_reg(sem_pkg::REG_FRAME_HEIGHT, 11'h7FF);
    repeat (board.frame_cols() * TALL_ROWS) push_random(TEXTURE_BINARY);

    // random geometry, mostly whole frames, some cut short and reshaped mid-frame
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      calm = (sent >= RANDOM_PIXELS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
      if (board.at_frame_start()) begin
        write_reg(sem_pkg::REG_FRAME_WIDTH, pick_dim());
        write_reg(sem_pkg::REG_FRAME_HEIGHT, pick_dim());
      end else begin
        h_val = pick_dim();
        write_reg(sem_pkg::REG_FRAME_HEIGHT, h_val);
        w_val = pick_dim();
        if (board.clamp_dim(w_val, sem_pkg::MAX_WIDTH) <= board.known_cols())
          write_reg(sem_pkg::REG_FRAME_WIDTH, w_val);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  11'($urandom_range(0, 2047)));
      tex = texture_t'($urandom_range(0, 2));
      w = board.frame_cols();
      h = board.frame_rows();
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, w * h - 1);
      repeat (n) push_random(tex);
      sent += n;
      if ($urandom_range(0, 3) != 0) begin
        while (!board.at_frame_start()) begin
          push_random(tex);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    n = 0;
    while (board.pending_edges.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    board.report_leftover();
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
